[hdl/assert_macros.svh]
// Assertion helpers for the RTL, included by i2c_master_bit_engine_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/i2cm_pkg.sv]
`default_nettype none
package i2cm_pkg;

	// Command codes as carried in the op field
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_WAIT  = 3'd5
	} op_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

	localparam logic [15:0] HALF_DELAY_RST  = 16'd10;
	localparam logic [9:0]  ACK_TIMEOUT_RST = 10'd250;
	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       sda_is_input;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} out_item_t;

	// Configuration as seen by the engine
	typedef struct packed {
		logic [15:0] half_delay_ticks;
		logic [9:0]  ack_timeout;
	} cfg_t;

endpackage
`default_nettype wire

[hdl/i2cm_engine.sv]
`default_nettype none
module i2cm_engine #(
	parameter int DELAY_COUNT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire i2cm_pkg::in_item_t item,
	input  wire i2cm_pkg::cfg_t     cfg,
	output i2cm_pkg::out_item_t    result
);
	import i2cm_pkg::*;

	localparam int W = DELAY_COUNT_BITS;

	op_t          cmd_q, cmd_n;
	logic [2:0]   phase_q, phase_n;
	logic [3:0]   bit_q, bit_n;
	logic [7:0]   shift_q, shift_n;
	logic [W-1:0] dly_q, dly_n;
	logic [9:0]   tmo_q, tmo_n;
	logic         scl_q, scl_n;
	logic         sda_q, sda_n;
	logic         dir_q, dir_n;
	logic         ack_seen_q, ack_seen_n;
	logic [7:0]   last_rx_q, last_rx_n;
	logic         ack_tx_q, ack_tx_n;

	logic         done;
	logic         miss;
	logic         do_poll;
	logic [W-1:0] load_val;
	logic [W-1:0] dly_dec;

	// Phase length: zero means one tick, saturate to the counter width
	always_comb begin
		if (cfg.half_delay_ticks == 16'd0) begin
			load_val = W'(1);
		end else if ((W < 16) && ((cfg.half_delay_ticks >> W) != 16'd0)) begin
			load_val = '1;
		end else begin
			load_val = W'(cfg.half_delay_ticks);
		end
	end

	assign dly_dec = (dly_q != '0) ? (dly_q - W'(1)) : dly_q;

	// One tick of the command sequencer
	always_comb begin
		cmd_n      = cmd_q;
		phase_n    = phase_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		dly_n      = dly_q;
		tmo_n      = tmo_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		dir_n      = dir_q;
		ack_seen_n = ack_seen_q;
		last_rx_n  = last_rx_q;
		ack_tx_n   = ack_tx_q;
		done       = 1'b0;
		miss       = 1'b0;
		do_poll    = 1'b0;

		if (cmd_q == OP_NONE) begin
			if ((item.op >= OP_START) && (item.op <= OP_WAIT)) begin
				cmd_n   = op_t'(item.op);
				bit_n   = 4'd0;
				tmo_n   = 10'd0;
				phase_n = 3'd0;
				dly_n   = load_val;
				case (op_t'(item.op))
					OP_START: begin
						dir_n = 1'b0; sda_n = 1'b1; scl_n = 1'b1;
					end
					OP_STOP: begin
						dir_n = 1'b0; sda_n = 1'b0; scl_n = 1'b1;
					end
					OP_WRITE: begin
						shift_n = item.tx_byte;
						dir_n = 1'b0; scl_n = 1'b0; sda_n = item.tx_byte[7];
					end
					OP_READ: begin
						shift_n  = 8'd0;
						ack_tx_n = item.send_ack;
						dir_n = 1'b1; scl_n = 1'b1;
					end
					default: begin
						ack_seen_n = 1'b0;
						dir_n = 1'b1; scl_n = 1'b1;
					end
				endcase
			end
		end else if (cmd_q == OP_WAIT && phase_q == 3'd1) begin
			do_poll = 1'b1;
		end else begin
			dly_n = dly_dec;
			if (dly_dec == '0) begin
				case (cmd_q)
					OP_START: begin
						if (phase_q == 3'd0) begin
							sda_n = 1'b0; phase_n = 3'd1; dly_n = load_val;
						end else if (phase_q == 3'd1) begin
							scl_n = 1'b0; phase_n = 3'd2; dly_n = load_val;
						end else begin
							done = 1'b1;
						end
					end
					OP_STOP: begin
						if (phase_q == 3'd0) begin
							sda_n = 1'b1; phase_n = 3'd1; dly_n = load_val;
						end else begin
							done = 1'b1;
						end
					end
					OP_WRITE: begin
						if (phase_q == 3'd0) begin
							scl_n = 1'b1; phase_n = 3'd1; dly_n = load_val;
						end else if (phase_q == 3'd1) begin
							scl_n = 1'b0; phase_n = 3'd2; dly_n = load_val;
						end else begin
							bit_n = bit_q + 4'd1;
							if ((bit_q + 4'd1) < BITS_PER_BYTE) begin
								shift_n = {shift_q[6:0], 1'b0};
								sda_n   = shift_q[6];
								phase_n = 3'd0;
								dly_n   = load_val;
							end else begin
								done = 1'b1;
							end
						end
					end
					OP_READ: begin
						if (phase_q == 3'd0) begin
							shift_n = {shift_q[6:0], item.sda_in};
							scl_n = 1'b0; phase_n = 3'd1; dly_n = load_val;
						end else if (phase_q == 3'd1) begin
							bit_n = bit_q + 4'd1;
							if ((bit_q + 4'd1) < BITS_PER_BYTE) begin
								scl_n = 1'b1; phase_n = 3'd0; dly_n = load_val;
							end else begin
								dir_n = 1'b0;
								sda_n = ~ack_tx_q;
								phase_n = 3'd2;
								dly_n = load_val;
							end
						end else if (phase_q == 3'd2) begin
							scl_n = 1'b1; phase_n = 3'd3; dly_n = load_val;
						end else if (phase_q == 3'd3) begin
							scl_n = 1'b0; phase_n = 3'd4; dly_n = load_val;
						end else begin
							sda_n     = 1'b1;
							last_rx_n = shift_q;
							done      = 1'b1;
						end
					end
					OP_WAIT: begin
						if (phase_q == 3'd0) begin
							phase_n = 3'd1;
							do_poll = 1'b1;
						end else if (phase_q == 3'd3) begin
							sda_n = 1'b1; phase_n = 3'd4; dly_n = load_val;
						end else begin
							done = 1'b1;
							miss = ~ack_seen_q;
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
		end

		// ACK sampling while SCL is high
		if (do_poll) begin
			if (!item.sda_in) begin
				ack_seen_n = 1'b1;
				scl_n = 1'b0; phase_n = 3'd2; dly_n = load_val;
			end else if (tmo_q >= cfg.ack_timeout) begin
				dir_n = 1'b0; sda_n = 1'b0; scl_n = 1'b1;
				phase_n = 3'd3; dly_n = load_val;
			end else begin
				tmo_n = tmo_q + 10'd1;
			end
		end

		if (done) begin
			cmd_n   = OP_NONE;
			phase_n = 3'd0;
		end
	end

	// Pin and status view after this tick
	always_comb begin
		result.scl_level    = scl_n;
		result.sda_release  = sda_n;
		result.sda_is_input = dir_n;
		result.busy_res     = (cmd_n != OP_NONE);
		result.done_res     = done;
		result.rx_byte      = last_rx_n;
		result.ack_missing  = miss;
	end

	// State update, one tick per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= OP_NONE;
			phase_q    <= 3'd0;
			bit_q      <= 4'd0;
			shift_q    <= 8'd0;
			dly_q      <= '0;
			tmo_q      <= 10'd0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			dir_q      <= 1'b0;
			ack_seen_q <= 1'b0;
			last_rx_q  <= 8'd0;
			ack_tx_q   <= 1'b0;
		end else if (fire) begin
			cmd_q      <= cmd_n;
			phase_q    <= phase_n;
			bit_q      <= bit_n;
			shift_q    <= shift_n;
			dly_q      <= dly_n;
			tmo_q      <= tmo_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			dir_q      <= dir_n;
			ack_seen_q <= ack_seen_n;
			last_rx_q  <= last_rx_n;
			ack_tx_q   <= ack_tx_n;
		end
	end

endmodule
`default_nettype wire

[hdl/i2c_master_bit_engine_core.sv]
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  in_data   (in_item_t: op, tx_byte, send_ack, sda_in)
// out      source     out_valid / out_stall out_data (out_item_t: pins, status, rx_byte)
// cfg      sink       cfg_wr_en            cfg_index, cfg_wdata
//
// One tick is taken per cycle while out is not stalled; each tick passes the input
// register, then the sequencer step into the result register.
// Reset puts the pins released, the engine idle and the registers to their
// defaults; no clearing pass, the first tick is taken right after reset.
// A stall on out holds the result register and backs up through the input
// register to in_stall in the same cycle.
`default_nettype none
module i2c_master_bit_engine_core #(
	parameter int DELAY_COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire i2cm_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output i2cm_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_wr_en,
	input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import i2cm_pkg::*;
	`include "assert_macros.svh"

	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv_s1;
	logic      in_xfer;
	cfg_t      cfg_q;
	out_item_t result;

	// Result register is free or being drained
	assign adv_s1   = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_delay_ticks <= HALF_DELAY_RST;
			cfg_q.ack_timeout      <= ACK_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HALF_DELAY:  cfg_q.half_delay_ticks <= cfg_wdata[15:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout      <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	i2cm_engine #(
		.DELAY_COUNT_BITS(DELAY_COUNT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_data <= result;
		end
	end

	`ASSERT_CLK(a_done_not_busy, !(out_valid && out_data.done_res && out_data.busy_res), "done with busy set")
	`ASSERT_CLK(a_miss_on_done, !(out_valid && out_data.ack_missing && !out_data.done_res), "ack_missing without done")
	`ASSERT_CLK(a_stall_needs_item, !(in_stall && !valid_s1), "input stalled with empty stage")
	`ASSERT_NEXT(a_drain, out_valid && !out_stall && !valid_s1, !out_valid, "result repeated")

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam int DCB = 16;
	localparam longint DELAY_CAP = (64'd1 << DCB) - 1;
	localparam int CYCLE_LIMIT = 3_000_000;

	// op codes outside the command set, and a register index that maps to nothing
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	i2c_master_bit_engine_core #(
		.DELAY_COUNT_BITS(DCB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Engine predictor: own copy of the sequencer state and registers
	// ---------------------------------------------------------------
	logic [15:0]    cfg_half = HALF_DELAY_RST;
	logic [9:0]     cfg_timeout = ACK_TIMEOUT_RST;

	op_t            eng_cmd = OP_NONE;
	logic [2:0]     eng_phase = '0;
	logic [3:0]     eng_bit = '0;
	logic [7:0]     eng_shift = '0;
	logic [DCB-1:0] eng_delay = '0;
	logic [9:0]     eng_tmo = '0;
	logic           eng_scl = 1'b1;
	logic           eng_sda = 1'b1;
	logic           eng_dir = 1'b0;
	logic           eng_ack_seen = 1'b0;
	logic [7:0]     eng_last_rx = '0;
	logic           eng_ack_to_send = 1'b0;
	logic           eng_done;
	logic           eng_miss;

	int begun_total = 0;
	int timeouts_seen = 0;

	// load the phase length; zero still lasts one tick, long ones saturate
	function automatic void eng_enter(input logic [2:0] ph);
		longint len;
		eng_phase = ph;
		len = (cfg_half == 0) ? 1 : longint'(cfg_half);
		if (len > DELAY_CAP)
			len = DELAY_CAP;
		eng_delay = len[DCB-1:0];
	endfunction

	function automatic void eng_finish();
		if (eng_cmd == OP_WAIT) begin
			eng_miss = !eng_ack_seen;
			if (eng_miss)
				timeouts_seen++;
		end
		eng_cmd = OP_NONE;
		eng_phase = '0;
		eng_done = 1'b1;
	endfunction

	// one SDA sample while SCL is high during wait-for-ACK
	function automatic void eng_poll(input logic sda);
		if (!sda) begin
			eng_ack_seen = 1'b1;
			eng_scl = 1'b0;
			eng_enter(3'd2);
		end else if (eng_tmo >= cfg_timeout) begin
			// give up: drive a stop
			eng_dir = 1'b0;
			eng_sda = 1'b0;
			eng_scl = 1'b1;
			eng_enter(3'd3);
		end else begin
			eng_tmo = eng_tmo + 1'b1;
		end
	endfunction

	// phase has run out: move to the next pin step
	function automatic void eng_advance(input logic sda);
		case (eng_cmd)
			OP_START: begin
				if (eng_phase == 0) begin
					eng_sda = 1'b0;
					eng_enter(3'd1);
				end else if (eng_phase == 1) begin
					eng_scl = 1'b0;
					eng_enter(3'd2);
				end else
					eng_finish();
			end
			OP_STOP: begin
				if (eng_phase == 0) begin
					eng_sda = 1'b1;
					eng_enter(3'd1);
				end else
					eng_finish();
			end
			OP_WRITE: begin
				if (eng_phase == 0) begin
					eng_scl = 1'b1;
					eng_enter(3'd1);
				end else if (eng_phase == 1) begin
					eng_scl = 1'b0;
					eng_enter(3'd2);
				end else begin
					eng_bit = eng_bit + 1'b1;
					if (eng_bit < BITS_PER_BYTE) begin
						eng_shift = eng_shift << 1;
						eng_sda = eng_shift[7];
						eng_enter(3'd0);
					end else
						eng_finish();
				end
			end
			OP_READ: begin
				if (eng_phase == 0) begin
					eng_shift = {eng_shift[6:0], sda};
					eng_scl = 1'b0;
					eng_enter(3'd1);
				end else if (eng_phase == 1) begin
					eng_bit = eng_bit + 1'b1;
					if (eng_bit < BITS_PER_BYTE) begin
						eng_scl = 1'b1;
						eng_enter(3'd0);
					end else begin
						// ACK/NACK bit from the master
						eng_dir = 1'b0;
						eng_sda = !eng_ack_to_send;
						eng_enter(3'd2);
					end
				end else if (eng_phase == 2) begin
					eng_scl = 1'b1;
					eng_enter(3'd3);
				end else if (eng_phase == 3) begin
					eng_scl = 1'b0;
					eng_enter(3'd4);
				end else begin
					eng_sda = 1'b1;
					eng_last_rx = eng_shift;
					eng_finish();
				end
			end
			OP_WAIT: begin
				if (eng_phase == 0) begin
					eng_phase = 3'd1;
					eng_poll(sda);
				end else if (eng_phase == 3) begin
					eng_sda = 1'b1;
					eng_enter(3'd4);
				end else
					eng_finish();
			end
			default: eng_finish();
		endcase
	endfunction

	function automatic void eng_accept(input in_item_t it);
		eng_cmd = op_t'(it.op);
		eng_bit = '0;
		eng_tmo = '0;
		begun_total++;
		case (it.op)
			OP_START: begin
				eng_dir = 1'b0;
				eng_sda = 1'b1;
				eng_scl = 1'b1;
			end
			OP_STOP: begin
				eng_dir = 1'b0;
				eng_sda = 1'b0;
				eng_scl = 1'b1;
			end
			OP_WRITE: begin
				eng_shift = it.tx_byte;
				eng_dir = 1'b0;
				eng_scl = 1'b0;
				eng_sda = it.tx_byte[7];
			end
			OP_READ: begin
				eng_shift = '0;
				eng_ack_to_send = it.send_ack;
				eng_dir = 1'b1;
				eng_scl = 1'b1;
			end
			default: begin
				eng_ack_seen = 1'b0;
				eng_dir = 1'b1;
				eng_scl = 1'b1;
			end
		endcase
		eng_enter(3'd0);
	endfunction

	// one tick in, the pin and status picture after it out
	function automatic out_item_t i2c_tick(input in_item_t it);
		out_item_t r;
		eng_done = 1'b0;
		eng_miss = 1'b0;
		if (eng_cmd == OP_NONE) begin
			if (it.op >= OP_START && it.op <= OP_WAIT)
				eng_accept(it);
		end else if (eng_cmd == OP_WAIT && eng_phase == 1) begin
			eng_poll(it.sda_in);
		end else begin
			if (eng_delay > 0)
				eng_delay = eng_delay - 1'b1;
			if (eng_delay == 0)
				eng_advance(it.sda_in);
		end
		r.scl_level = eng_scl;
		r.sda_release = eng_sda;
		r.sda_is_input = eng_dir;
		r.busy_res = (eng_cmd != OP_NONE);
		r.done_res = eng_done;
		r.rx_byte = eng_last_rx;
		r.ack_missing = eng_miss;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Tick driver
	// ---------------------------------------------------------------
	in_item_t  tick_queue[$];
	out_item_t expected_pins[$];
	int queued_total = 0;
	int accepted_total = 0;
	int drv_wait = 0;
	bit drv_burst = 1'b0;
	bit no_idle = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_pins.push_back(i2c_tick(in_data));
				accepted_total++;
				if ($urandom_range(0, 49) == 0)
					drv_burst = !drv_burst;
				drv_wait = (drv_burst || no_idle) ? 0 : $urandom_range(0, 4);
			end
			if (in_valid && in_stall) begin
				// hold the stalled transfer as it is
			end else if (drv_wait > 0) begin
				drv_wait--;
				in_valid <= 1'b0;
			end else if (tick_queue.size() > 0) begin
				in_data <= tick_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------
	int results_seen = 0;
	int mismatches = 0;
	int mon_wait = 0;
	bit mon_burst = 1'b0;
	out_item_t want;

	task automatic note_mismatch(input string what, input int want_v, input int got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: mismatch on %s at result %0d: expected %0h, got %0h",
				what, results_seen, want_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_pins.size() == 0) begin
					note_mismatch("unexpected result", 0, 1);
				end else begin
					want = expected_pins.pop_front();
					if (out_data.scl_level !== want.scl_level)
						note_mismatch("scl_level", want.scl_level, out_data.scl_level);
					if (out_data.sda_release !== want.sda_release)
						note_mismatch("sda_release", want.sda_release, out_data.sda_release);
					if (out_data.sda_is_input !== want.sda_is_input)
						note_mismatch("sda_is_input", want.sda_is_input, out_data.sda_is_input);
					if (out_data.busy_res !== want.busy_res)
						note_mismatch("busy_res", want.busy_res, out_data.busy_res);
					if (out_data.done_res !== want.done_res)
						note_mismatch("done_res", want.done_res, out_data.done_res);
					if (out_data.rx_byte !== want.rx_byte)
						note_mismatch("rx_byte", want.rx_byte, out_data.rx_byte);
					if (out_data.ack_missing !== want.ack_missing)
						note_mismatch("ack_missing", want.ack_missing, out_data.ack_missing);
				end
				if ($urandom_range(0, 49) == 0)
					mon_burst = !mon_burst;
				mon_wait = (mon_burst || no_idle) ? 0 : $urandom_range(0, 4);
			end
			if (mon_wait > 0) begin
				mon_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Run length guard
	// ---------------------------------------------------------------
	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input logic sda);
		in_item_t t;
		t.op = op;
		t.tx_byte = tx;
		t.send_ack = ack;
		t.sda_in = sda;
		tick_queue.push_back(t);
		queued_total++;
	endtask

	// a command followed by enough plain ticks to carry it through;
	// for wait-for-ACK, SDA goes low ack_after samples into the polling
	task automatic push_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input int ack_after, input int sda_fix, input int noise_pct);
		int span, n, i;
		logic [2:0] fop;
		logic sda;
		span = (cfg_half == 0) ? 1 : int'(cfg_half);
		case (op)
			OP_START: n = 3 * span;
			OP_STOP:  n = 2 * span;
			OP_WRITE: n = 24 * span;
			OP_READ:  n = 19 * span;
			OP_WAIT:  n = 3 * span + ((ack_after > cfg_timeout) ? cfg_timeout + 1 : ack_after);
			default:  n = 0;
		endcase
		push_tick(op, tx, ack, 1'($urandom_range(0, 1)));
		for (i = 0; i < n; i++) begin
			fop = OP_NONE;
			if ($urandom_range(0, 99) < noise_pct)
				fop = 3'($urandom_range(0, 7));
			if (op == OP_WAIT)
				sda = (i < span - 1 + ack_after);
			else if (sda_fix >= 0)
				sda = sda_fix[0];
			else
				sda = 1'($urandom_range(0, 1));
			push_tick(fop, 8'($urandom), 1'($urandom_range(0, 1)), sda);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (accepted_total != queued_total || expected_pins.size() != 0);
	endtask

	// run the engine back to idle so that registers may be written
	task automatic settle();
		wait_drained();
		while (eng_cmd != OP_NONE) begin
			repeat (8)
				push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			wait_drained();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_HALF_DELAY)
			cfg_half = val;
		else if (idx == REG_ACK_TIMEOUT)
			cfg_timeout = val[9:0];
	endtask

	task automatic run_random(input int cmds, input bit pause_mid);
		int k, s, t, lim, ack_after;
		logic [2:0] op;
		for (k = 0; k < cmds; k++) begin
			t = cfg_timeout;
			if ($urandom_range(0, 99) < 5) begin
				case ($urandom_range(0, 2))
					0: op = OP_NONE;
					1: op = OP_RSVD6;
					default: op = OP_RSVD7;
				endcase
			end else begin
				op = 3'($urandom_range(OP_START, OP_WAIT));
			end
			// mostly a quick ACK, sometimes right at the timeout, sometimes none
			s = $urandom_range(0, 9);
			lim = (t + 1 < 12) ? t + 1 : 12;
			if (s < 7)
				ack_after = $urandom_range(0, lim);
			else if (s < 9)
				ack_after = (t > 0) ? t - 1 + $urandom_range(0, 2) : $urandom_range(0, 2);
			else
				ack_after = t + 4;
			push_command(op, 8'($urandom), 1'($urandom_range(0, 1)), ack_after, -1, 3);
			if (pause_mid && k == cmds / 2)
				wait_drained();
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, register defaults
		push_command(OP_START, 8'h00, 1'b0, 0, -1, 0);
		push_command(OP_WRITE, 8'hA5, 1'b0, 0, -1, 0);
		push_command(OP_WAIT, 8'h00, 1'b0, 3, -1, 0);
		push_command(OP_STOP, 8'h00, 1'b0, 0, -1, 0);
		push_tick(OP_RSVD6, 8'hFF, 1'b1, 1'b1);
		push_tick(OP_RSVD7, 8'h00, 1'b0, 1'b0);
		settle();

		// directed, shortest phases and no timeout slack
		write_reg(REG_HALF_DELAY, 16'd0);
		write_reg(REG_ACK_TIMEOUT, 16'd0);
		push_command(OP_WRITE, 8'h00, 1'b0, 0, -1, 0);
		push_command(OP_WRITE, 8'hFF, 1'b1, 0, -1, 0);
		push_command(OP_READ, 8'h00, 1'b0, 0, 1, 0);
		push_command(OP_READ, 8'hFF, 1'b1, 0, 0, 0);
		push_command(OP_WAIT, 8'h00, 1'b0, 0, -1, 0);
		push_command(OP_WAIT, 8'h00, 1'b0, 5, -1, 0);
		// commands arriving while busy must be dropped
		push_command(OP_START, 8'h3C, 1'b1, 0, -1, 100);
		settle();
		run_random(15, 1'b1);

		write_reg(REG_HALF_DELAY, 16'd1);
		write_reg(REG_ACK_TIMEOUT, 16'd3);
		run_random(10, 1'b0);

		// widest timeout, acknowledged early
		write_reg(REG_HALF_DELAY, 16'd2);
		write_reg(REG_ACK_TIMEOUT, 16'd1023);
		push_command(OP_WRITE, 8'h5A, 1'b0, 0, -1, 0);
		push_command(OP_WAIT, 8'h00, 1'b0, 7, -1, 0);
		settle();

		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_HALF_DELAY, 16'($urandom_range(3, 7)));
		write_reg(REG_ACK_TIMEOUT, 16'($urandom_range(0, 30)));
		run_random(3, 1'b1);

		// ticks back to back, no stalls on either side
		no_idle = 1'b1;
		write_reg(REG_HALF_DELAY, 16'd0);
		write_reg(REG_ACK_TIMEOUT, 16'd1);
		run_random(12, 1'b0);
		no_idle = 1'b0;

		repeat (20) @(posedge clk);
		if (expected_pins.size() != 0)
			$display("tb: %0d results never arrived", expected_pins.size());
		$display("tb: %0d ticks checked, %0d commands begun, %0d ended without ACK",
			results_seen, begun_total, timeouts_seen);
		$display("tb: phase lengths 0 to 10 ticks, ACK timeouts 0 to 1023 samples");
		if (mismatches == 0 && expected_pins.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
